// File: hw/rtl/ntw_pkg.sv
// ============================================================================
// ntw_pkg - shared types, word codes and control program of the number speller
// Holds the control word layout, the opcodes and the read-only program that
// steps through digit groups and picks the English word codes to send.
// ============================================================================
package ntw_pkg;

    localparam int ValueW    = 64;
    localparam int ShiftCntW = $clog2(ValueW);
    localparam int NumDigits = 20;
    localparam int BcdW      = 4 * NumDigits;
    localparam int CodeW     = 6;
    localparam int PcW       = 6;
    localparam int CntW      = 6;
    localparam int MaxWords  = 35;

    // word codes
    localparam logic [CodeW-1:0] CodeZero     = 6'd0;
    localparam logic [CodeW-1:0] CodeTeenBase = 6'd10;
    localparam logic [CodeW-1:0] CodeTensBase = 6'd18;
    localparam logic [CodeW-1:0] CodeHundred  = 6'd28;
    localparam logic [CodeW-1:0] CodeThousand = 6'd29;
    localparam logic [CodeW-1:0] CodeMillion  = 6'd30;
    localparam logic [CodeW-1:0] CodeBillion  = 6'd31;
    localparam logic [CodeW-1:0] CodeTrillion = 6'd32;
    localparam logic [CodeW-1:0] CodeQuadrill = 6'd33;
    localparam logic [CodeW-1:0] CodeQuintill = 6'd34;
    localparam logic [CodeW-1:0] CodeLakh     = 6'd35;
    localparam logic [CodeW-1:0] CodeCrore    = 6'd36;
    localparam logic [CodeW-1:0] CodeArab     = 6'd37;
    localparam logic [CodeW-1:0] CodeKharab   = 6'd38;
    localparam logic [CodeW-1:0] CodeNeel     = 6'd39;
    localparam logic [CodeW-1:0] CodePadma    = 6'd40;
    localparam logic [CodeW-1:0] CodeNegative = 6'd41;

    // program entry points
    localparam logic [PcW-1:0] AddrEnd      = 6'd35;
    localparam logic [PcW-1:0] AddrIndStart = 6'd36;

    typedef enum logic [3:0] {
        OP_JMODE,   // jump to target in Indian grouping
        OP_NEG,     // negative if the input was negative
        OP_HUND,    // hundreds digit word
        OP_HWORD,   // the word hundred
        OP_TENS,    // twenty..ninety
        OP_ONES,    // one..nineteen, hyphenated after a tens word
        OP_SCALE,   // scale word if the group is not zero
        OP_ZERO,    // zero if nothing kept
        OP_JUMP,    // unconditional jump
        OP_END      // flush the held word as the last one
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [4:0]       pos;     // digit index of the group's ones digit
        logic             hund;    // group has a hundreds digit
        logic [CodeW-1:0] code;    // scale word
        logic [PcW-1:0]   target;  // jump target
    } ctl_word_t;

    typedef struct packed {
        logic busy;
        logic done;
    } ntw_status_t;

    function automatic ctl_word_t mk(op_t op, logic [4:0] pos, logic hund,
                                     logic [CodeW-1:0] code, logic [PcW-1:0] target);
        ctl_word_t w;
        w.op     = op;
        w.pos    = pos;
        w.hund   = hund;
        w.code   = code;
        w.target = target;
        return w;
    endfunction

    // Control program. International: entries 1..35, Indian: 36..63.
    function automatic ctl_word_t ucode(logic [PcW-1:0] addr);
        ctl_word_t w;
        unique case (addr)
            6'd0:  w = mk(OP_JMODE, 5'd0,  1'b0, CodeZero, AddrIndStart);
            6'd1:  w = mk(OP_NEG,   5'd0,  1'b0, CodeZero, AddrEnd);
            // quintillion group: two digits only
            6'd2:  w = mk(OP_TENS,  5'd18, 1'b0, CodeZero, AddrEnd);
            6'd3:  w = mk(OP_ONES,  5'd18, 1'b0, CodeZero, AddrEnd);
            6'd4:  w = mk(OP_SCALE, 5'd18, 1'b0, CodeQuintill, AddrEnd);
            // quadrillion
            6'd5:  w = mk(OP_HUND,  5'd15, 1'b1, CodeZero, AddrEnd);
            6'd6:  w = mk(OP_HWORD, 5'd15, 1'b1, CodeZero, AddrEnd);
            6'd7:  w = mk(OP_TENS,  5'd15, 1'b1, CodeZero, AddrEnd);
            6'd8:  w = mk(OP_ONES,  5'd15, 1'b1, CodeZero, AddrEnd);
            6'd9:  w = mk(OP_SCALE, 5'd15, 1'b1, CodeQuadrill, AddrEnd);
            // trillion
            6'd10: w = mk(OP_HUND,  5'd12, 1'b1, CodeZero, AddrEnd);
            6'd11: w = mk(OP_HWORD, 5'd12, 1'b1, CodeZero, AddrEnd);
            6'd12: w = mk(OP_TENS,  5'd12, 1'b1, CodeZero, AddrEnd);
            6'd13: w = mk(OP_ONES,  5'd12, 1'b1, CodeZero, AddrEnd);
            6'd14: w = mk(OP_SCALE, 5'd12, 1'b1, CodeTrillion, AddrEnd);
            // billion
            6'd15: w = mk(OP_HUND,  5'd9,  1'b1, CodeZero, AddrEnd);
            6'd16: w = mk(OP_HWORD, 5'd9,  1'b1, CodeZero, AddrEnd);
            6'd17: w = mk(OP_TENS,  5'd9,  1'b1, CodeZero, AddrEnd);
            6'd18: w = mk(OP_ONES,  5'd9,  1'b1, CodeZero, AddrEnd);
            6'd19: w = mk(OP_SCALE, 5'd9,  1'b1, CodeBillion, AddrEnd);
            // million
            6'd20: w = mk(OP_HUND,  5'd6,  1'b1, CodeZero, AddrEnd);
            6'd21: w = mk(OP_HWORD, 5'd6,  1'b1, CodeZero, AddrEnd);
            6'd22: w = mk(OP_TENS,  5'd6,  1'b1, CodeZero, AddrEnd);
            6'd23: w = mk(OP_ONES,  5'd6,  1'b1, CodeZero, AddrEnd);
            6'd24: w = mk(OP_SCALE, 5'd6,  1'b1, CodeMillion, AddrEnd);
            // thousand
            6'd25: w = mk(OP_HUND,  5'd3,  1'b1, CodeZero, AddrEnd);
            6'd26: w = mk(OP_HWORD, 5'd3,  1'b1, CodeZero, AddrEnd);
            6'd27: w = mk(OP_TENS,  5'd3,  1'b1, CodeZero, AddrEnd);
            6'd28: w = mk(OP_ONES,  5'd3,  1'b1, CodeZero, AddrEnd);
            6'd29: w = mk(OP_SCALE, 5'd3,  1'b1, CodeThousand, AddrEnd);
            // units
            6'd30: w = mk(OP_HUND,  5'd0,  1'b1, CodeZero, AddrEnd);
            6'd31: w = mk(OP_HWORD, 5'd0,  1'b1, CodeZero, AddrEnd);
            6'd32: w = mk(OP_TENS,  5'd0,  1'b1, CodeZero, AddrEnd);
            6'd33: w = mk(OP_ONES,  5'd0,  1'b1, CodeZero, AddrEnd);
            6'd34: w = mk(OP_ZERO,  5'd0,  1'b0, CodeZero, AddrEnd);
            6'd35: w = mk(OP_END,   5'd0,  1'b0, CodeZero, AddrEnd);
            // Indian grouping
            6'd36: w = mk(OP_NEG,   5'd0,  1'b0, CodeZero, AddrEnd);
            6'd37: w = mk(OP_TENS,  5'd15, 1'b0, CodeZero, AddrEnd);
            6'd38: w = mk(OP_ONES,  5'd15, 1'b0, CodeZero, AddrEnd);
            6'd39: w = mk(OP_SCALE, 5'd15, 1'b0, CodePadma, AddrEnd);
            6'd40: w = mk(OP_TENS,  5'd13, 1'b0, CodeZero, AddrEnd);
            6'd41: w = mk(OP_ONES,  5'd13, 1'b0, CodeZero, AddrEnd);
            6'd42: w = mk(OP_SCALE, 5'd13, 1'b0, CodeNeel, AddrEnd);
            6'd43: w = mk(OP_TENS,  5'd11, 1'b0, CodeZero, AddrEnd);
            6'd44: w = mk(OP_ONES,  5'd11, 1'b0, CodeZero, AddrEnd);
            6'd45: w = mk(OP_SCALE, 5'd11, 1'b0, CodeKharab, AddrEnd);
            6'd46: w = mk(OP_TENS,  5'd9,  1'b0, CodeZero, AddrEnd);
            6'd47: w = mk(OP_ONES,  5'd9,  1'b0, CodeZero, AddrEnd);
            6'd48: w = mk(OP_SCALE, 5'd9,  1'b0, CodeArab, AddrEnd);
            6'd49: w = mk(OP_TENS,  5'd7,  1'b0, CodeZero, AddrEnd);
            6'd50: w = mk(OP_ONES,  5'd7,  1'b0, CodeZero, AddrEnd);
            6'd51: w = mk(OP_SCALE, 5'd7,  1'b0, CodeCrore, AddrEnd);
            6'd52: w = mk(OP_TENS,  5'd5,  1'b0, CodeZero, AddrEnd);
            6'd53: w = mk(OP_ONES,  5'd5,  1'b0, CodeZero, AddrEnd);
            6'd54: w = mk(OP_SCALE, 5'd5,  1'b0, CodeLakh, AddrEnd);
            6'd55: w = mk(OP_TENS,  5'd3,  1'b0, CodeZero, AddrEnd);
            6'd56: w = mk(OP_ONES,  5'd3,  1'b0, CodeZero, AddrEnd);
            6'd57: w = mk(OP_SCALE, 5'd3,  1'b0, CodeThousand, AddrEnd);
            6'd58: w = mk(OP_HUND,  5'd0,  1'b1, CodeZero, AddrEnd);
            6'd59: w = mk(OP_HWORD, 5'd0,  1'b1, CodeZero, AddrEnd);
            6'd60: w = mk(OP_TENS,  5'd0,  1'b1, CodeZero, AddrEnd);
            6'd61: w = mk(OP_ONES,  5'd0,  1'b1, CodeZero, AddrEnd);
            6'd62: w = mk(OP_ZERO,  5'd0,  1'b0, CodeZero, AddrEnd);
            6'd63: w = mk(OP_JUMP,  5'd0,  1'b0, CodeZero, AddrEnd);
            default: w = mk(OP_END, 5'd0,  1'b0, CodeZero, AddrEnd);
        endcase
        return w;
    endfunction

endpackage

// File: hw/rtl/number_to_word_tokens.sv
// ============================================================================
// number_to_word_tokens - spells a signed 64-bit integer as English words
// Converts the magnitude to decimal, then runs a small control program that
// sends the word codes of each request one at a time, most significant first.
// ============================================================================
// Each number passes the binary-to-decimal shifter, then the program: up to 36
// steps for international grouping, 30 for Indian, and may stall while m_tready
// is low. The next number is accepted once the sequencer's done flag clears the
// busy register, after the last word of the previous one enters the result
// register. Results carry word_code, hyphen_before and truncated in m_tdata and
// last_word in m_tlast. The user must write numbering_system through
// cfg_wr_en/cfg_wr_data only while the block is idle; the block does not enforce this.
module number_to_word_tokens (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,   // numbering_system
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,       // [63:0] value
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,       // [5:0] word_code, [6] hyphen_before, [7] truncated
    output logic        m_tlast        // last_word
);
    import ntw_pkg::*;

    logic              mode_reg;
    logic              busy_reg;
    logic              neg_reg;
    logic              accept;
    logic [ValueW-1:0] mag;
    logic [BcdW-1:0]   bcd;
    ntw_status_t       bcd_st;
    ntw_status_t       seq_st;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = !busy_reg;
    // two's complement magnitude; the most negative value gives 2^63
    assign mag      = s_tdata[63] ? (~s_tdata + 64'd1) : s_tdata;

    // configuration and run control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= 1'b0;
            busy_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                mode_reg <= cfg_wr_data;
            end
            if (accept) begin
                busy_reg <= 1'b1;
            end else if (seq_st.done) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            neg_reg <= s_tdata[63];
        end
    end

    ntw_bcd u_bcd (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start_i  (accept),
        .mag_i    (mag),
        .bcd_o    (bcd),
        .status_o (bcd_st)
    );

    ntw_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start_i  (bcd_st.done),
        .mode_i   (mode_reg),
        .neg_i    (neg_reg),
        .bcd_i    (bcd),
        .status_o (seq_st),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // a request starts the converter
    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> bcd_st.busy)
        else $error("converter not started by request");

    // converter and sequencer never run together
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(bcd_st.busy && seq_st.busy))
        else $error("converter and sequencer overlap");

    // word codes stay in range
    a_code_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[5:0] <= CodeNegative))
        else $error("word code out of range");

    // only a ones word is hyphenated
    a_hyphen_ones: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[6]) |-> (m_tdata[5:0] >= 6'd1 && m_tdata[5:0] <= 6'd9))
        else $error("hyphen on a word that is not a ones word");

endmodule

// File: hw/rtl/ntw_bcd.sv
// ============================================================================
// ntw_bcd - binary to decimal converter
// Shift-and-add-three, one magnitude bit per cycle; the twenty decimal digits
// stay stable until the next start.
// ============================================================================
module ntw_bcd (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start_i,
    input  logic [ntw_pkg::ValueW-1:0]  mag_i,
    output logic [ntw_pkg::BcdW-1:0]    bcd_o,
    output ntw_pkg::ntw_status_t        status_o
);
    import ntw_pkg::*;

    logic [ValueW-1:0]         bin_reg;
    logic [BcdW-1:0]           bcd_reg;
    logic [BcdW-1:0]           bcd_adj;
    logic [ShiftCntW-1:0]      cnt_reg;
    logic                      busy_reg;
    logic                      done_reg;

    // add three to every digit of five or more before the shift
    always_comb begin
        for (int d = 0; d < NumDigits; d++) begin
            bcd_adj[4*d +: 4] = (bcd_reg[4*d +: 4] >= 4'd5) ?
                                bcd_reg[4*d +: 4] + 4'd3 : bcd_reg[4*d +: 4];
        end
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start_i) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == ShiftCntW'(ValueW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // shift datapath
    always_ff @(posedge aclk) begin
        if (start_i) begin
            bin_reg <= mag_i;
            bcd_reg <= '0;
        end else if (busy_reg) begin
            bin_reg <= {bin_reg[ValueW-2:0], 1'b0};
            bcd_reg <= {bcd_adj[BcdW-2:0], bin_reg[ValueW-1]};
        end
    end

    assign bcd_o         = bcd_reg;
    assign status_o.busy = busy_reg;
    assign status_o.done = done_reg;

endmodule

// File: hw/rtl/ntw_seq.sv
// ============================================================================
// ntw_seq - microcoded word sequencer
// Steps through the control program one step per cycle while the result side
// does not stall it, holds the newest word until the next one (or the end)
// shows whether it is the last, and drives the result register.
// ============================================================================
module ntw_seq (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start_i,
    input  logic                        mode_i,
    input  logic                        neg_i,
    input  logic [ntw_pkg::BcdW-1:0]    bcd_i,
    output ntw_pkg::ntw_status_t        status_o,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [7:0]                  m_tdata,
    output logic                        m_tlast
);
    import ntw_pkg::*;

    typedef struct packed {
        logic [CodeW-1:0] code;
        logic             hyphen;
    } word_t;

    logic [PcW-1:0]  pc_reg, pc_next;
    logic [CntW-1:0] count_reg;
    logic            run_reg;
    logic            done_reg;
    logic            pend_valid_reg;
    word_t           pend_reg;
    logic            m_valid_reg;
    logic [7:0]      m_data_reg;
    logic            m_last_reg;

    ctl_word_t         cw;
    logic [BcdW+7:0]   bcd_ext;
    logic [11:0]       win;
    logic [3:0]        dh, dt, d1;
    logic              emit;
    word_t             new_word;
    logic              is_end;
    logic              push;
    logic              stall;
    logic              trunc;
    logic              kept_zero;

    assign cw      = ucode(pc_reg);
    assign bcd_ext = {8'd0, bcd_i};
    assign win     = bcd_ext[{cw.pos, 2'b00} +: 12];
    assign dh      = win[11:8];
    assign dt      = win[7:4];
    assign d1      = win[3:0];

    // digits at and above ten to the seventeenth are dropped in Indian mode
    assign trunc     = mode_i && (bcd_i[BcdW-1:68] != '0);
    assign kept_zero = mode_i ? (bcd_i[67:0] == '0) : (bcd_i == '0);

    // word decode
    always_comb begin
        emit            = 1'b0;
        new_word.code   = CodeZero;
        new_word.hyphen = 1'b0;
        unique case (cw.op)
            OP_NEG: begin
                emit          = neg_i;
                new_word.code = CodeNegative;
            end
            OP_HUND: begin
                emit          = (dh != 4'd0);
                new_word.code = {2'b00, dh};
            end
            OP_HWORD: begin
                emit          = (dh != 4'd0);
                new_word.code = CodeHundred;
            end
            OP_TENS: begin
                emit          = (dt >= 4'd2);
                new_word.code = CodeTensBase + {2'b00, dt};
            end
            OP_ONES: begin
                if (dt == 4'd1) begin
                    emit          = 1'b1;
                    new_word.code = CodeTeenBase + {2'b00, d1};
                end else begin
                    emit            = (d1 != 4'd0);
                    new_word.code   = {2'b00, d1};
                    new_word.hyphen = (dt >= 4'd2);
                end
            end
            OP_SCALE: begin
                emit          = (d1 != 4'd0) || (dt != 4'd0) || (cw.hund && dh != 4'd0);
                new_word.code = cw.code;
            end
            OP_ZERO: begin
                emit          = kept_zero;
                new_word.code = CodeZero;
            end
            OP_JMODE, OP_JUMP, OP_END: begin
                emit = 1'b0;
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    assign is_end = (cw.op == OP_END);
    assign push   = (emit && pend_valid_reg) || is_end;
    assign stall  = push && m_valid_reg && !m_tready;

    // next step
    always_comb begin
        pc_next = pc_reg + 1'b1;
        if (cw.op == OP_JMODE && mode_i) begin
            pc_next = cw.target;
        end else if (cw.op == OP_JUMP) begin
            pc_next = cw.target;
        end else if (emit && count_reg == CntW'(MaxWords - 1)) begin
            // word limit reached: the word just taken becomes the last one
            pc_next = AddrEnd;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg        <= 1'b0;
            done_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
            pc_reg         <= '0;
            count_reg      <= '0;
        end else begin
            done_reg <= 1'b0;
            if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (start_i) begin
                run_reg        <= 1'b1;
                pend_valid_reg <= 1'b0;
                pc_reg         <= '0;
                count_reg      <= '0;
            end else if (run_reg && !stall) begin
                if (push) begin
                    m_valid_reg <= 1'b1;
                end
                if (is_end) begin
                    run_reg        <= 1'b0;
                    pend_valid_reg <= 1'b0;
                    done_reg       <= 1'b1;
                end else if (emit) begin
                    pend_valid_reg <= 1'b1;
                    count_reg      <= count_reg + 1'b1;
                end
                pc_reg <= pc_next;
            end
        end
    end

    // held word and result payload
    always_ff @(posedge aclk) begin
        if (run_reg && !stall) begin
            if (push) begin
                m_data_reg <= {trunc, pend_reg.hyphen, pend_reg.code};
                m_last_reg <= is_end;
            end
            if (emit) begin
                pend_reg <= new_word;
            end
        end
    end

    assign status_o.busy = run_reg;
    assign status_o.done = done_reg;
    assign m_tvalid      = m_valid_reg;
    assign m_tdata       = m_data_reg;
    assign m_tlast       = m_last_reg;

endmodule
